### rtl/psatm_pkg.sv
// ----------------------------------------------------------------------------
// psatm_pkg: shared types and constants for the sensor average monitor
// Field widths, status codes, register indexes and divider sizing.
// ----------------------------------------------------------------------------
package psatm_pkg;

    // payload field widths
    localparam int ID_W     = 8;
    localparam int SAMPLE_W = 16;
    localparam int STATUS_W = 2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_NORMAL  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_HOT     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_COLD    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd3;

    // configuration register map
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_HOT_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLD_LIMIT = 1'd1;

    // reset values of the limits, Q8.8 (50.0 and 10.0 degrees)
    localparam logic signed [SAMPLE_W-1:0] HOT_LIMIT_RST  = 16'sd12800;
    localparam logic signed [SAMPLE_W-1:0] COLD_LIMIT_RST = 16'sd2560;

    // divider: quotient bits resolved per cycle and iteration count
    localparam int DIV_BITS   = 2;
    localparam int DIV_ITERS  = SAMPLE_W / DIV_BITS;
    localparam int DIV_ITER_W = $clog2(DIV_ITERS);

endpackage

### rtl/psatm_ram.sv
// ----------------------------------------------------------------------------
// psatm_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module psatm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/per_sensor_average_threshold_monitor.sv
// ----------------------------------------------------------------------------
// per_sensor_average_threshold_monitor: windowed average and limit check
// Keeps a window of recent Q8.8 readings per sensor and reports the average
// and whether it lies above the hot limit or below the cold limit.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (i_valid/o_ready) carry a sensor number and a reading. Each
//   beat gives exactly one output beat (o_valid/i_ready) with the sensor
//   number, a status code and the window average.
//   The block takes one beat at a time. For a valid sensor the work runs
//   through the per-sensor fill state (S_META), streams the filled window
//   entries (up to WINDOW) out of the sample RAM into one adder (S_SUM),
//   compares (S_CMP), runs a 2-bit-per-cycle divider (S_DIV) and loads the
//   output register (S_DONE). An invalid sensor number goes straight to the
//   output load. o_ready returns the cycle after the result loads, so the
//   next beat is taken only after the current result is through.
//   Limits are written through i_cfg_we/i_cfg_index/i_cfg_data while idle.
//   Reset (synchronous, active low) empties every window at once through
//   per-sensor valid bits and restores the limits to 50.0 and 10.0 degrees;
//   no clearing pass is needed.
//   A result waits in the output register while i_ready is low; the block
//   still accepts the next beat and stalls only when the following result
//   is ready to load.
// ----------------------------------------------------------------------------
module per_sensor_average_threshold_monitor
    import psatm_pkg::*;
#(
    parameter int SENSOR_COUNT = 64,
    parameter int WINDOW       = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ID_W-1:0]             i_sensor_id,
    input  logic signed [SAMPLE_W-1:0]  i_temperature,
    // output channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ID_W-1:0]             o_sensor_echo,
    output logic [STATUS_W-1:0]         o_status,
    output logic signed [SAMPLE_W-1:0]  o_average,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [SAMPLE_W-1:0]         i_cfg_data
);

    localparam int SID_W   = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int META_W  = CNT_W + POS_W;
    localparam int DEPTH   = SENSOR_COUNT * WINDOW;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W   = SAMPLE_W + CNT_W;
    localparam int CMP_W   = SUM_W + 1;
    localparam logic [ID_W:0]      SENSOR_LIMIT = (ID_W + 1)'(SENSOR_COUNT);
    localparam logic [CNT_W-1:0]   WIN_FULL     = CNT_W'(WINDOW);
    localparam logic [POS_W-1:0]   POS_LAST     = POS_W'(WINDOW - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_META = 6'b000010,
        S_SUM  = 6'b000100,
        S_CMP  = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state                     r_state;
    logic [ID_W-1:0]            r_id;
    logic signed [SAMPLE_W-1:0] r_temp;
    logic [AW-1:0]              r_base;
    logic [CNT_W-1:0]           r_cnt;
    logic [CNT_W-1:0]           r_rd_idx;
    logic                       r_pend;
    logic signed [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]           r_rem;
    logic [SAMPLE_W-1:0]        r_quot;
    logic                       r_neg;
    logic [DIV_ITER_W-1:0]      r_div_iter;
    logic [STATUS_W-1:0]        r_status;
    logic [SENSOR_COUNT-1:0]    r_meta_vld;
    logic signed [SAMPLE_W-1:0] r_hot_limit;
    logic signed [SAMPLE_W-1:0] r_cold_limit;
    logic                       r_out_valid;
    logic [ID_W-1:0]            r_out_id;
    logic [STATUS_W-1:0]        r_out_status;
    logic [SAMPLE_W-1:0]        r_out_avg;

    logic                       in_beat;
    logic                       id_bad;
    logic [SID_W-1:0]           sid;
    logic [META_W-1:0]          meta_rdata;
    logic [CNT_W-1:0]           meta_cnt;
    logic [POS_W-1:0]           meta_pos;
    logic                       win_full;
    logic [POS_W-1:0]           slot;
    logic [CNT_W-1:0]           n_cnt;
    logic [POS_W-1:0]           n_pos;
    logic                       meta_we;
    logic [AW-1:0]              store_waddr;
    logic [AW-1:0]              store_raddr;
    logic [SAMPLE_W-1:0]        store_rdata;
    logic                       rd_issue;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [CMP_W-1:0]    sum_ext;
    logic signed [CMP_W-1:0]    hot_prod;
    logic signed [CMP_W-1:0]    cold_prod;
    logic [STATUS_W-1:0]        n_status;
    logic [SUM_W-1:0]           sum_mag;
    logic [CNT_W:0]             d_rem;
    logic [SAMPLE_W-1:0]        d_quot;
    logic                       out_load;

    assign in_beat = i_valid && o_ready;
    assign id_bad  = {1'b0, i_sensor_id} >= SENSOR_LIMIT;
    assign sid     = r_id[SID_W-1:0];
    assign o_ready = (r_state == S_IDLE);

    // per-sensor fill state; an entry never written since reset reads as empty
    assign meta_cnt = r_meta_vld[sid] ? meta_rdata[META_W-1:POS_W] : '0;
    assign meta_pos = r_meta_vld[sid] ? meta_rdata[POS_W-1:0] : '0;
    assign win_full = (meta_cnt == WIN_FULL);
    assign slot     = win_full ? meta_pos : POS_W'(meta_cnt);
    assign n_cnt    = win_full ? meta_cnt : meta_cnt + 1'b1;
    assign n_pos    = !win_full ? meta_pos :
                      (meta_pos == POS_LAST) ? '0 : meta_pos + 1'b1;
    assign meta_we  = (r_state == S_META);

    psatm_ram #(
        .WIDTH (META_W),
        .DEPTH (SENSOR_COUNT)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (sid),
        .i_wdata ({n_cnt, n_pos}),
        .i_raddr (i_sensor_id[SID_W-1:0]),
        .o_rdata (meta_rdata)
    );

    // sample window store
    assign store_waddr = r_base + AW'(slot);
    assign store_raddr = r_base + AW'(r_rd_idx);

    psatm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (store_waddr),
        .i_wdata (r_temp),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    // streaming accumulate, one sample per cycle
    assign rd_issue = (r_rd_idx < r_cnt);
    assign n_sum    = r_pend ?
                      r_sum + {{(SUM_W-SAMPLE_W){store_rdata[SAMPLE_W-1]}}, store_rdata} :
                      r_sum;

    // exact limit check against sum, hot wins over cold
    assign sum_ext   = {r_sum[SUM_W-1], r_sum};
    assign hot_prod  = r_hot_limit * $signed({1'b0, r_cnt});
    assign cold_prod = r_cold_limit * $signed({1'b0, r_cnt});

    always_comb begin
        if (sum_ext > hot_prod) begin
            n_status = STATUS_HOT;
        end else if (sum_ext < cold_prod) begin
            n_status = STATUS_COLD;
        end else begin
            n_status = STATUS_NORMAL;
        end
    end

    assign sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : r_sum;

    // restoring divider, two quotient bits per cycle
    always_comb begin
        d_rem  = {1'b0, r_rem};
        d_quot = r_quot;
        for (int k = 0; k < DIV_BITS; k++) begin
            d_rem  = {d_rem[CNT_W-1:0], d_quot[SAMPLE_W-1]};
            d_quot = {d_quot[SAMPLE_W-2:0], 1'b0};
            if (d_rem >= {1'b0, r_cnt}) begin
                d_rem     = d_rem - {1'b0, r_cnt};
                d_quot[0] = 1'b1;
            end
        end
    end

    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_meta_vld <= '0;
            r_pend     <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_state <= id_bad ? S_DONE : S_META;
                    end
                end
                S_META: begin
                    r_meta_vld[sid] <= 1'b1;
                    r_state         <= S_SUM;
                end
                S_SUM: begin
                    r_pend <= rd_issue;
                    if (!rd_issue && !r_pend) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_div_iter == DIV_ITER_W'(DIV_ITERS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_id     <= i_sensor_id;
            r_temp   <= i_temperature;
            r_base   <= AW'(int'(i_sensor_id) * WINDOW);
            r_status <= STATUS_INVALID;
            r_quot   <= '0;
            r_neg    <= 1'b0;
        end
        if (r_state == S_META) begin
            r_cnt    <= n_cnt;
            r_rd_idx <= '0;
            r_sum    <= '0;
        end
        if (r_state == S_SUM) begin
            r_sum <= n_sum;
            if (rd_issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end
        if (r_state == S_CMP) begin
            r_status   <= n_status;
            r_neg      <= r_sum[SUM_W-1];
            r_rem      <= sum_mag[SUM_W-1:SAMPLE_W];
            r_quot     <= sum_mag[SAMPLE_W-1:0];
            r_div_iter <= '0;
        end
        if (r_state == S_DIV) begin
            r_rem      <= d_rem[CNT_W-1:0];
            r_quot     <= d_quot;
            r_div_iter <= r_div_iter + 1'b1;
        end
    end

    // limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hot_limit  <= HOT_LIMIT_RST;
            r_cold_limit <= COLD_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_HOT_LIMIT:  r_hot_limit  <= i_cfg_data;
                REG_COLD_LIMIT: r_cold_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_id     <= r_id;
            r_out_status <= r_status;
            r_out_avg    <= r_neg ? SAMPLE_W'(-r_quot) : r_quot;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_sensor_echo = r_out_id;
    assign o_status      = r_out_status;
    assign o_average     = r_out_avg;

endmodule

### tb/per_sensor_average_threshold_monitor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_sensor_average_threshold_monitor_tb: self-checking bench for the monitor
// Drives sensor readings with random gaps and random output back-pressure.
// Checks every result against a windowed-average model kept in the bench,
// or against the result a typed directed row carries. A short table of
// directed readings comes first. Random phases with different hot and cold limits follow.
// ----------------------------------------------------------------------------
module per_sensor_average_threshold_monitor_tb;
    import psatm_pkg::*;

    localparam int SENSOR_COUNT       = 64;
    localparam int WINDOW             = 8;
    localparam int CLK_HALF           = 6;
    localparam int RESET_CYCLES       = 3;
    localparam int RANDOM_PHASES      = 7;
    localparam int READINGS_PER_PHASE = 150;
    localparam int DIRECTED_ROWS      = 27;
    localparam int IDLE_LIMIT         = 1000;
    localparam int DRAIN_CYCLES       = 30;
    localparam int MAX_REPORTS        = 10;

    localparam logic signed [SAMPLE_W-1:0] Q_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] Q_MAX = 16'sh7FFF;

    typedef struct packed {
        logic [ID_W-1:0]            echo;
        logic [STATUS_W-1:0]        status;
        logic signed [SAMPLE_W-1:0] average;
    } t_reading_result;

    typedef enum logic {ROW_READ, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind                  kind;
        logic [ID_W-1:0]            id;
        logic signed [SAMPLE_W-1:0] value;
        logic [CFG_IDX_W-1:0]       cfg_reg;
        bit                         typed;
        logic [STATUS_W-1:0]        status;
        logic signed [SAMPLE_W-1:0] average;
    } t_stim_row;

    // directed readings; typed rows carry their expected result, checked in place of the model
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{ROW_READ, 8'd0,   16'sd12801, REG_HOT_LIMIT,  1'b1, STATUS_HOT,     16'sd12801},
        '{ROW_READ, 8'd1,   16'sd12800, REG_HOT_LIMIT,  1'b1, STATUS_NORMAL,  16'sd12800},
        '{ROW_READ, 8'd2,   16'sd2559,  REG_HOT_LIMIT,  1'b1, STATUS_COLD,    16'sd2559},
        '{ROW_READ, 8'd3,   16'sd2560,  REG_HOT_LIMIT,  1'b1, STATUS_NORMAL,  16'sd2560},
        '{ROW_READ, 8'd64,  16'sd1234,  REG_HOT_LIMIT,  1'b1, STATUS_INVALID, 16'sd0},
        '{ROW_READ, 8'd255, Q_MIN,      REG_HOT_LIMIT,  1'b1, STATUS_INVALID, 16'sd0},
        '{ROW_READ, 8'd63,  Q_MAX,      REG_HOT_LIMIT,  1'b1, STATUS_HOT,     Q_MAX},
        '{ROW_READ, 8'd62,  Q_MIN,      REG_HOT_LIMIT,  1'b1, STATUS_COLD,    Q_MIN},
        '{ROW_READ, 8'd4,   -16'sd1,    REG_HOT_LIMIT,  1'b1, STATUS_COLD,    -16'sd1},
        // negative sums truncate toward zero
        '{ROW_READ, 8'd4,   16'sd0,     REG_HOT_LIMIT,  1'b0, STATUS_NORMAL,  16'sd0},
        '{ROW_READ, 8'd4,   -16'sd2,    REG_HOT_LIMIT,  1'b0, STATUS_NORMAL,  16'sd0},
        // fill one window and wrap onto the oldest slot
        '{ROW_READ, 8'd5,   Q_MAX,      REG_HOT_LIMIT,  1'b0, STATUS_NORMAL,  16'sd0},
        '{ROW_READ, 8'd5,   Q_MAX,      REG_HOT_LIMIT,  1'b0, STATUS_NORMAL,  16'sd0},
        '{ROW_READ, 8'd5,   Q_MIN,      REG_HOT_LIMIT,  1'b0, STATUS_NORMAL,  16'sd0},
        '{ROW_READ, 8'd5,   16'sd12800, REG_HOT_LIMIT,  1'b0, STATUS_NORMAL,  16'sd0},
        '{ROW_READ, 8'd5,   16'sd100,   REG_HOT_LIMIT,  1'b0, STATUS_NORMAL,  16'sd0},
        '{ROW_READ, 8'd5,   -16'sd100,  REG_HOT_LIMIT,  1'b0, STATUS_NORMAL,  16'sd0},
        '{ROW_READ, 8'd5,   16'sd3,     REG_HOT_LIMIT,  1'b0, STATUS_NORMAL,  16'sd0},
        '{ROW_READ, 8'd5,   Q_MIN,      REG_HOT_LIMIT,  1'b0, STATUS_NORMAL,  16'sd0},
        '{ROW_READ, 8'd5,   16'sd7,     REG_HOT_LIMIT,  1'b0, STATUS_NORMAL,  16'sd0},
        // hot limit below cold limit: overheating wins
        '{ROW_CFG,  8'd0,   Q_MIN,      REG_HOT_LIMIT,  1'b0, STATUS_NORMAL,  16'sd0},
        '{ROW_CFG,  8'd0,   Q_MAX,      REG_COLD_LIMIT, 1'b0, STATUS_NORMAL,  16'sd0},
        '{ROW_READ, 8'd6,   16'sd0,     REG_HOT_LIMIT,  1'b1, STATUS_HOT,     16'sd0},
        // widest band: extreme readings stay normal
        '{ROW_CFG,  8'd0,   Q_MAX,      REG_HOT_LIMIT,  1'b0, STATUS_NORMAL,  16'sd0},
        '{ROW_CFG,  8'd0,   Q_MIN,      REG_COLD_LIMIT, 1'b0, STATUS_NORMAL,  16'sd0},
        '{ROW_READ, 8'd7,   Q_MAX,      REG_HOT_LIMIT,  1'b1, STATUS_NORMAL,  Q_MAX},
        '{ROW_READ, 8'd8,   Q_MIN,      REG_HOT_LIMIT,  1'b1, STATUS_NORMAL,  Q_MIN}
    };

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_ready;
    logic [ID_W-1:0]             i_sensor_id;
    logic signed [SAMPLE_W-1:0]  i_temperature;
    logic                        o_valid;
    logic                        i_ready = 1'b1;
    logic [ID_W-1:0]             o_sensor_echo;
    logic [STATUS_W-1:0]         o_status;
    logic signed [SAMPLE_W-1:0]  o_average;
    logic                        i_cfg_we;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [SAMPLE_W-1:0]         i_cfg_data;

    // typed expectation that rides along with the current input beat
    bit                          typed_valid;
    t_reading_result             typed_result;

    // model state: per-sensor windows and the two limits
    logic signed [SAMPLE_W-1:0]  window_samples [SENSOR_COUNT][WINDOW];
    int                          fill_count     [SENSOR_COUNT];
    int                          oldest_slot    [SENSOR_COUNT];
    logic signed [SAMPLE_W-1:0]  hot_lim;
    logic signed [SAMPLE_W-1:0]  cold_lim;

    t_reading_result             pending_results [$];
    bit                          no_idle;
    int                          ready_hold;
    int                          stalled_cycles;
    int                          fail_count;
    int                          readings_sent;
    int                          results_checked;
    int                          config_writes;
    int                          status_seen [4];

    per_sensor_average_threshold_monitor #(
        .SENSOR_COUNT(SENSOR_COUNT),
        .WINDOW      (WINDOW)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sensor_id  (i_sensor_id),
        .i_temperature(i_temperature),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sensor_echo(o_sensor_echo),
        .o_status     (o_status),
        .o_average    (o_average),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // store one reading in its window and work out average and status
    function automatic t_reading_result window_average(input logic [ID_W-1:0] id,
                                                       input logic signed [SAMPLE_W-1:0] temp);
        t_reading_result r;
        int              sum;
        int              cnt;
        int              k;
        r.echo = id;
        if (id >= SENSOR_COUNT) begin
            r.status  = STATUS_INVALID;
            r.average = '0;
            return r;
        end
        if (fill_count[id] < WINDOW) begin
            window_samples[id][fill_count[id]] = temp;
            fill_count[id]++;
        end else begin
            window_samples[id][oldest_slot[id]] = temp;
            oldest_slot[id] = (oldest_slot[id] + 1) % WINDOW;
        end
        cnt = fill_count[id];
        sum = 0;
        for (k = 0; k < cnt; k++)
            sum += int'(window_samples[id][k]);
        r.average = SAMPLE_W'(sum / cnt);
        if (sum > int'(hot_lim) * cnt)
            r.status = STATUS_HOT;
        else if (sum < int'(cold_lim) * cnt)
            r.status = STATUS_COLD;
        else
            r.status = STATUS_NORMAL;
        return r;
    endfunction

    // present one reading after a random gap and wait for its beat
    task automatic send_reading(input logic [ID_W-1:0] id,
                                input logic signed [SAMPLE_W-1:0] temp,
                                input bit has_typed, input t_reading_result typed);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_sensor_id   <= id;
        i_temperature <= temp;
        typed_valid   <= has_typed;
        typed_result  <= typed;
        @(posedge i_clk);
        while (!(i_valid && o_ready)) @(posedge i_clk);
    endtask

    // one limit write; the last write of a group drops the enable
    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx,
                               input logic [SAMPLE_W-1:0] value, input bit last);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        if (idx == REG_HOT_LIMIT)
            hot_lim = value;
        else
            cold_lim = value;
        config_writes++;
        if (last)
            i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drain();
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // output side: random stall after each beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ready_hold = 0;
            i_ready <= 1'b1;
        end else if (o_valid && i_ready) begin
            ready_hold = no_idle ? 0 : $urandom_range(0, 3);
            i_ready <= (ready_hold == 0);
        end else if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            i_ready <= (ready_hold == 0);
        end
    end

    // compare output beats, then record the expectation of each input beat
    always @(posedge i_clk) begin : result_check
        t_reading_result got;
        t_reading_result want;
        t_reading_result predicted;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got = {o_sensor_echo, o_status, o_average};
                results_checked++;
                status_seen[o_status]++;
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: sensor %0d status %0d average %0d",
                                 o_sensor_echo, o_status, o_average);
                end else begin
                    want = pending_results.pop_front();
                    if (got.echo !== want.echo || got.status !== want.status ||
                        got.average !== want.average) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("mismatch: got sensor %0d status %0d average %0d, %s %0d %0d %0d",
                                     got.echo, got.status, $signed(got.average),
                                     "expected", want.echo, want.status, $signed(want.average));
                    end
                end
            end
            if (i_valid && o_ready) begin
                predicted = window_average(i_sensor_id, i_temperature);
                pending_results.push_back(typed_valid ? typed_result : predicted);
                readings_sent++;
            end
        end
    end

    // watchdog on cycles with no beat and no register write
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= IDLE_LIMIT) begin
            $display("no progress for %0d cycles", IDLE_LIMIT);
            $display("** per_sensor_average_threshold_monitor: FAILED **");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial begin
        logic signed [SAMPLE_W-1:0] phase_hot  [RANDOM_PHASES];
        logic signed [SAMPLE_W-1:0] phase_cold [RANDOM_PHASES];
        logic signed [SAMPLE_W-1:0] lim_a;
        logic signed [SAMPLE_W-1:0] lim_b;
        logic [ID_W-1:0]            id;
        logic signed [SAMPLE_W-1:0] temp;
        int                         pick;
        int                         near;

        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_sensor_id   <= '0;
        i_temperature <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_HOT_LIMIT;
        i_cfg_data    <= '0;
        typed_valid   <= 1'b0;
        typed_result  <= '0;
        no_idle       = 1'b0;
        for (int s = 0; s < SENSOR_COUNT; s++) begin
            fill_count[s]  = 0;
            oldest_slot[s] = 0;
        end
        hot_lim  = HOT_LIMIT_RST;
        cold_lim = COLD_LIMIT_RST;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                if (r > 0 && directed_rows[r-1].kind == ROW_READ) begin
                    i_valid <= 1'b0;
                    wait_drain();
                end
                write_limit(directed_rows[r].cfg_reg, directed_rows[r].value,
                            r == DIRECTED_ROWS - 1 || directed_rows[r+1].kind != ROW_CFG);
            end else begin
                send_reading(directed_rows[r].id, directed_rows[r].value, directed_rows[r].typed,
                             {directed_rows[r].id, directed_rows[r].status,
                              directed_rows[r].average});
            end
        end
        i_valid <= 1'b0;
        wait_drain();

        // limit settings of the random phases
        phase_hot[0] = HOT_LIMIT_RST;  phase_cold[0] = COLD_LIMIT_RST;
        phase_hot[1] = 16'sd5000;      phase_cold[1] = -16'sd5000;
        phase_hot[2] = Q_MIN;          phase_cold[2] = Q_MAX;
        phase_hot[3] = Q_MAX;          phase_cold[3] = Q_MIN;
        phase_hot[4] = SAMPLE_W'($urandom);
        phase_cold[4] = SAMPLE_W'($urandom);
        phase_hot[5] = 16'sd0;         phase_cold[5] = 16'sd0;
        lim_a = SAMPLE_W'($urandom);
        lim_b = SAMPLE_W'($urandom);
        phase_hot[6]  = (lim_a > lim_b) ? lim_a : lim_b;
        phase_cold[6] = (lim_a > lim_b) ? lim_b : lim_a;

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_limit(REG_HOT_LIMIT, phase_hot[p], 1'b0);
            write_limit(REG_COLD_LIMIT, phase_cold[p], 1'b1);
            // one phase runs back to back on both sides
            no_idle = (p == 1);
            for (int n = 0; n < READINGS_PER_PHASE; n++) begin
                // mostly a few busy sensors so windows fill and wrap
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    id = ID_W'($urandom_range(0, 7));
                else if (pick < 85)
                    id = ID_W'($urandom_range(0, SENSOR_COUNT - 1));
                else
                    id = ID_W'($urandom_range(SENSOR_COUNT, 255));
                // extremes, readings near a limit, or anything
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    temp = pick[0] ? Q_MAX : Q_MIN;
                end else if (pick < 55) begin
                    near = int'(pick[0] ? hot_lim : cold_lim)
                           + int'($urandom_range(0, 600)) - 300;
                    if (near > 32767)
                        near = 32767;
                    if (near < -32768)
                        near = -32768;
                    temp = SAMPLE_W'(near);
                end else begin
                    temp = SAMPLE_W'($urandom);
                end
                send_reading(id, temp, 1'b0, '0);
            end
            i_valid <= 1'b0;
            wait_drain();
        end
        no_idle = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d readings over %0d limit writes; results normal %0d hot %0d cold %0d",
                 readings_sent, config_writes, status_seen[STATUS_NORMAL],
                 status_seen[STATUS_HOT], status_seen[STATUS_COLD]);
        $display("invalid sensor ids %0d, results checked %0d, mismatches %0d",
                 status_seen[STATUS_INVALID], results_checked, fail_count);
        if (fail_count == 0)
            $display("** per_sensor_average_threshold_monitor: PASSED **");
        else
            $display("** per_sensor_average_threshold_monitor: FAILED **");
        $finish;
    end

endmodule
